// ===== hdl/qhb_pkg.sv =====
package qhb_pkg;

  // Engine modes, coded as the direction field
  typedef enum logic [1:0] {
    MODE_NEUTRAL = 2'd0,
    MODE_BACK    = 2'd1,
    MODE_FORWARD = 2'd2,
    MODE_BRAKE   = 2'd3
  } mode_e;

  // Item kinds
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_SET  = 1'b1;

  // Field and state widths
  localparam int unsigned ENGINES   = 4;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned POWER_W   = 7;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PINS_W    = 2 * ENGINES;
  localparam int unsigned PRODUCT_W = POWER_W + COUNT_W;

  // Power and duty scaling
  localparam logic [POWER_W-1:0] MAX_POWER   = 7'd100;
  localparam logic [COUNT_W-1:0] DUTY_OFFSET = 16'd70;

  // floor(x / 100) = (x * RECIP_MUL) >> RECIP_SHIFT for x below 2^23
  localparam int unsigned        RECIP_W     = 24;
  localparam int unsigned        RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 24'd10737419;

  // Configuration port
  localparam int unsigned        ADDR_W        = 3;
  localparam int unsigned        DATA_W        = 32;
  localparam logic               REG_PWM_PERIOD = 1'b0;
  localparam logic [COUNT_W-1:0] PERIOD_RESET  = 16'd400;

  // Item held between the scaling stage and the bridge state stage
  typedef struct packed {
    logic                 action;
    logic [SEL_W-1:0]     engine_sel;
    mode_e                mode;
    logic [PRODUCT_W-1:0] product;
  } stage_t;

endpackage

// ===== hdl/qhb_in_if.sv =====
interface qhb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [qhb_pkg::SEL_W-1:0]     engine_sel;
  logic [1:0]                    direction;
  logic [qhb_pkg::POWER_W-1:0]   power_pct;

  modport source (output valid, action, engine_sel, direction, power_pct, input ready);
  modport sink   (input valid, action, engine_sel, direction, power_pct, output ready);
endinterface

// ===== hdl/qhb_out_if.sv =====
interface qhb_out_if;
  logic                        valid;
  logic                        ready;
  logic [qhb_pkg::PINS_W-1:0]  bridge_pins;

  modport source (output valid, bridge_pins, input ready);
  modport sink   (input valid, bridge_pins, output ready);
endinterface

// ===== hdl/qhb_apb_regs.sv =====
module qhb_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qhb_pkg::ADDR_W-1:0]   paddr,
  input  logic [qhb_pkg::DATA_W-1:0]   pwdata,
  output logic [qhb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [qhb_pkg::COUNT_W-1:0]  pwm_period_o
);

  logic                         wr_en;
  logic                         reg_idx;
  logic [qhb_pkg::COUNT_W-1:0]  period_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[qhb_pkg::ADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  // Take the period on the access cycle of a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= qhb_pkg::PERIOD_RESET;
    end else if (wr_en && (reg_idx == qhb_pkg::REG_PWM_PERIOD)) begin
      period_q <= pwdata[qhb_pkg::COUNT_W-1:0];
    end
  end

  // Read back the period, zero elsewhere
  always_comb begin
    if (reg_idx == qhb_pkg::REG_PWM_PERIOD) begin
      prdata = {{(qhb_pkg::DATA_W - qhb_pkg::COUNT_W){1'b0}}, period_q};
    end else begin
      prdata = '0;
    end
  end

  assign pwm_period_o = period_q;

endmodule

// ===== hdl/qhb_duty_mul.sv =====
module qhb_duty_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qhb_in_if.sink                       in_i,
  input  logic [qhb_pkg::COUNT_W-1:0]  pwm_period_i,
  input  logic                         advance_i,
  output qhb_pkg::stage_t              stage_o,
  output logic                         stage_valid_o
);

  logic                            valid_q;
  qhb_pkg::stage_t                 stage_q;
  qhb_pkg::stage_t                 stage_d;
  logic [qhb_pkg::POWER_W-1:0]     power_sat;
  logic [qhb_pkg::COUNT_W-1:0]     span;
  logic                            take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  // Saturate power, fold zero power into neutral unless braking, scale the period span
  always_comb begin
    power_sat = (in_i.power_pct > qhb_pkg::MAX_POWER) ? qhb_pkg::MAX_POWER : in_i.power_pct;
    span      = (pwm_period_i > qhb_pkg::DUTY_OFFSET) ?
                (pwm_period_i - qhb_pkg::DUTY_OFFSET) : '0;
    stage_d.action     = in_i.action;
    stage_d.engine_sel = in_i.engine_sel;
    if ((power_sat == '0) && (qhb_pkg::mode_e'(in_i.direction) != qhb_pkg::MODE_BRAKE)) begin
      stage_d.mode = qhb_pkg::MODE_NEUTRAL;
    end else begin
      stage_d.mode = qhb_pkg::mode_e'(in_i.direction);
    end
    stage_d.product = qhb_pkg::PRODUCT_W'(power_sat) * qhb_pkg::PRODUCT_W'(span);
  end

  // Hold the stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Load the payload on a transfer
  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o       = stage_q;
  assign stage_valid_o = valid_q;

endmodule

// ===== hdl/qhb_bridge_core.sv =====
module qhb_bridge_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qhb_pkg::stage_t              stage_i,
  input  logic                         stage_valid_i,
  input  logic [qhb_pkg::COUNT_W-1:0]  pwm_period_i,
  output logic                         advance_o,
  qhb_out_if.source                    out_o
);

  localparam int unsigned RPROD_W = qhb_pkg::PRODUCT_W + qhb_pkg::RECIP_W;

  logic                            out_valid_q;
  logic                            fire;
  logic [qhb_pkg::COUNT_W-1:0]     cnt_q, cnt_d;
  logic [qhb_pkg::COUNT_W-1:0]     cnt_next;
  logic                            wrap;
  logic [qhb_pkg::PINS_W-1:0]      pins_q, pins_d;
  logic [qhb_pkg::PINS_W-1:0]      run_mask;
  logic [qhb_pkg::COUNT_W-1:0]     duty_q [qhb_pkg::ENGINES];
  logic [qhb_pkg::COUNT_W-1:0]     duty_d [qhb_pkg::ENGINES];
  qhb_pkg::mode_e                  mode_q [qhb_pkg::ENGINES];
  qhb_pkg::mode_e                  mode_d [qhb_pkg::ENGINES];
  logic [RPROD_W-1:0]              recip_prod;
  logic [qhb_pkg::COUNT_W-1:0]     duty_new;

  // Pin that a running engine drives, none for idle engines
  function automatic logic [qhb_pkg::PINS_W-1:0] active_mask(qhb_pkg::mode_e m, int unsigned n);
    logic [qhb_pkg::PINS_W-1:0] mask;
    mask = '0;
    case (m)
      qhb_pkg::MODE_FORWARD: mask[2*n]     = 1'b1;
      qhb_pkg::MODE_BACK:    mask[2*n + 1] = 1'b1;
      default:               mask          = '0;
    endcase
    return mask;
  endfunction

  assign advance_o = !out_valid_q || out_o.ready;
  assign fire      = stage_valid_i && advance_o;

  // Divide the registered product by 100 through the reciprocal
  assign recip_prod = RPROD_W'(stage_i.product) * RPROD_W'(qhb_pkg::RECIP_MUL);
  assign duty_new   = recip_prod[qhb_pkg::RECIP_SHIFT +: qhb_pkg::COUNT_W];

  // Counter step and the wrap decision
  assign wrap     = (cnt_q >= pwm_period_i);
  assign cnt_next = wrap ? '0 : (cnt_q + qhb_pkg::COUNT_W'(1));

  always_comb begin
    run_mask = '0;
    for (int unsigned n = 0; n < qhb_pkg::ENGINES; n++) begin
      run_mask = run_mask | active_mask(mode_q[n], n);
    end
  end

  // Next state for one item
  always_comb begin
    cnt_d  = cnt_q;
    pins_d = pins_q;
    duty_d = duty_q;
    mode_d = mode_q;
    if (fire) begin
      if (stage_i.action == qhb_pkg::ACTION_SET) begin
        mode_d[stage_i.engine_sel] = stage_i.mode;
        case (stage_i.mode)
          qhb_pkg::MODE_FORWARD, qhb_pkg::MODE_BACK: begin
            duty_d[stage_i.engine_sel]        = duty_new;
            cnt_d                             = '0;
            pins_d[{stage_i.engine_sel, 1'b0} +: 2] = 2'b00;
          end
          qhb_pkg::MODE_BRAKE: begin
            pins_d[{stage_i.engine_sel, 1'b0} +: 2] = 2'b11;
          end
          default: begin
            pins_d[{stage_i.engine_sel, 1'b0} +: 2] = 2'b00;
          end
        endcase
      end else begin
        cnt_d = cnt_next;
        if (wrap) begin
          pins_d = pins_d | run_mask;
        end
        // Drop the pin of each running engine whose duty is reached
        for (int unsigned n = 0; n < qhb_pkg::ENGINES; n++) begin
          if (duty_q[n] == cnt_next) begin
            pins_d = pins_d & ~active_mask(mode_q[n], n);
          end
        end
      end
    end
  end

  // Hold bridge state and the result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pins_q      <= '0;
      for (int unsigned n = 0; n < qhb_pkg::ENGINES; n++) begin
        duty_q[n] <= '0;
        mode_q[n] <= qhb_pkg::MODE_NEUTRAL;
      end
    end else begin
      if (advance_o) begin
        out_valid_q <= stage_valid_i;
      end
      cnt_q  <= cnt_d;
      pins_q <= pins_d;
      duty_q <= duty_d;
      mode_q <= mode_d;
    end
  end

  // Pins change only together with a new result, so they serve as the result register
  assign out_o.valid       = out_valid_q;
  assign out_o.bridge_pins = pins_q;

  // A tick below the period advances the counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (stage_i.action == qhb_pkg::ACTION_TICK) && !wrap)
      |=> (cnt_q == $past(cnt_q) + qhb_pkg::COUNT_W'(1)))
    else $error("tick did not advance the counter");

  // Starting an engine restarts the shared counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (stage_i.action == qhb_pkg::ACTION_SET) &&
     ((stage_i.mode == qhb_pkg::MODE_FORWARD) || (stage_i.mode == qhb_pkg::MODE_BACK)))
      |=> (cnt_q == '0))
    else $error("counter not cleared on engine start");

  // Pins of each engine agree with its mode
  for (genvar g = 0; g < qhb_pkg::ENGINES; g++) begin : g_pin_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((mode_q[g] == qhb_pkg::MODE_NEUTRAL) && (pins_q[2*g +: 2] == 2'b00)) ||
      ((mode_q[g] == qhb_pkg::MODE_BRAKE)   && (pins_q[2*g +: 2] == 2'b11)) ||
      ((mode_q[g] == qhb_pkg::MODE_FORWARD) && !pins_q[2*g + 1]) ||
      ((mode_q[g] == qhb_pkg::MODE_BACK)    && !pins_q[2*g]))
      else $error("bridge pins disagree with engine mode");
  end

endmodule

// ===== hdl/quad_hbridge_pwm_driver_core.sv =====
// Path: a result is offered after its input passes through two register stages.
// Throughput: one item per cycle while the result side is ready; the duty scaling
// multiply and the state update sit in separate register stages, so ticks and mode
// changes run back to back.
// Reset (rst_ni, asynchronous, active low): period 400, counter, duties and pins
// zero, every engine neutral, both pipeline stages empty.
module quad_hbridge_pwm_driver_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qhb_in_if.sink                       in_i,
  qhb_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qhb_pkg::ADDR_W-1:0]   paddr,
  input  logic [qhb_pkg::DATA_W-1:0]   pwdata,
  output logic [qhb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [qhb_pkg::COUNT_W-1:0]  pwm_period;
  qhb_pkg::stage_t              stage;
  logic                         stage_valid;
  logic                         advance;

  qhb_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pwm_period_o (pwm_period)
  );

  qhb_duty_mul u_duty_mul (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .pwm_period_i  (pwm_period),
    .advance_i     (advance),
    .stage_o       (stage),
    .stage_valid_o (stage_valid)
  );

  qhb_bridge_core u_bridge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .stage_valid_i (stage_valid),
    .pwm_period_i  (pwm_period),
    .advance_o     (advance),
    .out_o         (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import qhb_pkg::*;

  localparam logic [ADDR_W-1:0] PERIOD_ADDR = ADDR_W'(4 * REG_PWM_PERIOD);

  // Bridge state tracker and store of pin levels still to come out
  class pin_scoreboard;
    logic [COUNT_W-1:0] period;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] duty [ENGINES];
    mode_e              mode [ENGINES];
    logic [PINS_W-1:0]  pins;
    logic [PINS_W-1:0]  expected_pins [$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      period       = PERIOD_RESET;
      count        = '0;
      pins         = '0;
      mismatches   = 0;
      results_seen = 0;
      for (int n = 0; n < ENGINES; n++) begin
        duty[n] = '0;
        mode[n] = MODE_NEUTRAL;
      end
    endfunction

    // Pin driven by a running engine, none for neutral or brake
    function logic [PINS_W-1:0] drive_mask(int n);
      case (mode[n])
        MODE_FORWARD: return PINS_W'(1) << (2 * n);
        MODE_BACK:    return PINS_W'(1) << (2 * n + 1);
        default:      return '0;
      endcase
    endfunction

    function void apply_mode(logic [SEL_W-1:0] sel, logic [1:0] dir,
                             logic [POWER_W-1:0] power);
      logic [POWER_W-1:0] pw;
      mode_e              m;
      logic [COUNT_W-1:0] span;
      int unsigned        product;
      logic [PINS_W-1:0]  both;
      pw   = (power > MAX_POWER) ? MAX_POWER : power;
      m    = mode_e'(dir);
      both = PINS_W'(2'b11) << (2 * sel);
      // zero power parks the engine unless it is braking
      if (pw == '0 && m != MODE_BRAKE) m = MODE_NEUTRAL;
      mode[sel] = m;
      case (m)
        MODE_FORWARD, MODE_BACK: begin
          span      = (period > DUTY_OFFSET) ? period - DUTY_OFFSET : '0;
          product   = pw * span;
          duty[sel] = COUNT_W'(product / MAX_POWER);
          count     = '0;
          pins      = pins & ~both;
        end
        MODE_BRAKE: begin
          pins = pins | both;
        end
        default: begin
          pins = pins & ~both;
        end
      endcase
    endfunction

    function void advance_count();
      // wrap raises every active pin, otherwise step the counter
      if (count >= period) begin
        count = '0;
        for (int n = 0; n < ENGINES; n++) pins = pins | drive_mask(n);
      end else begin
        count = count + 1'b1;
      end
      // a duty match drops the active pin, even on the wrap itself
      for (int n = 0; n < ENGINES; n++) begin
        if (drive_mask(n) != '0 && duty[n] == count) pins = pins & ~drive_mask(n);
      end
    endfunction

    function void note_item(logic action, logic [SEL_W-1:0] sel, logic [1:0] dir,
                            logic [POWER_W-1:0] power);
      if (action == ACTION_SET) apply_mode(sel, dir, power);
      else advance_count();
      expected_pins.push_back(pins);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_pins(logic [PINS_W-1:0] got);
      logic [PINS_W-1:0] want;
      results_seen++;
      if (expected_pins.size() == 0) begin
        report($sformatf("bridge_pins %02h with no item outstanding", got));
      end else begin
        want = expected_pins.pop_front();
        if (got !== want)
          report($sformatf("bridge_pins %02h, expected %02h", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  bit                calm = 1'b0;

  pin_scoreboard sb = new();

  qhb_in_if  in_if ();
  qhb_out_if out_if ();

  quad_hbridge_pwm_driver_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Watch both channels: note each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_item(in_if.action, in_if.engine_sel, in_if.direction, in_if.power_pct);
      if (out_if.valid && out_if.ready) sb.check_pins(out_if.bridge_pins);
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin
    int unsigned stall_cycles;
    bit          held;
    held         = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.results_seen >= 500) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        for (stall_cycles = 0; stall_cycles < 300; stall_cycles++) @(posedge clk);
      end
      out_if.ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item and hold it until the transfer
  task automatic send_item(logic action, logic [SEL_W-1:0] sel, logic [1:0] dir,
                           logic [POWER_W-1:0] power);
    while (!calm && $urandom_range(99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= action;
    in_if.engine_sel <= sel;
    in_if.direction  <= dir;
    in_if.power_pct  <= power;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_random(logic action);
    logic [POWER_W-1:0] power;
    int unsigned        pick;
    pick  = $urandom_range(9);
    power = (pick == 0) ? '0 :
            (pick == 1) ? POWER_W'($urandom_range(127, 101)) :
                          POWER_W'($urandom_range(100, 1));
    send_item(action, SEL_W'($urandom_range(3)), 2'($urandom_range(3)), power);
  endtask

  // Frames of a few mode changes followed by a run of ticks
  task automatic run_phase(int unsigned budget);
    int unsigned sent;
    int unsigned span;
    int unsigned stretch;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(3, 1)) begin
        send_random(ACTION_SET);
        sent++;
      end
      // long enough to reach a wrap where the period is short
      span = 2 * sb.period + 4;
      if (span > 220) span = 220;
      stretch = $urandom_range(span, 1);
      // keep the phase within its budget
      if (sent >= budget) stretch = 0;
      else if (stretch > budget - sent) stretch = budget - sent;
      repeat (stretch) begin
        send_random(($urandom_range(99) == 0) ? ACTION_SET : ACTION_TICK);
        sent++;
      end
    end
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drain the pipeline, then write the period over the register port
  task automatic change_period(logic [COUNT_W-1:0] value);
    in_if.valid <= 1'b0;
    wait_drain();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PERIOD_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.period = value;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ACTION_TICK;
    in_if.engine_sel = '0;
    in_if.direction  = '0;
    in_if.power_pct  = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: saturation, zero power, brake at zero power, every engine and mode
    send_item(ACTION_TICK, 2'd0, MODE_NEUTRAL, 7'd0);
    send_item(ACTION_SET, 2'd0, MODE_FORWARD, 7'd100);
    send_item(ACTION_SET, 2'd1, MODE_BACK, 7'd127);
    send_item(ACTION_SET, 2'd2, MODE_BRAKE, 7'd0);
    send_item(ACTION_SET, 2'd3, MODE_FORWARD, 7'd0);
    send_item(ACTION_SET, 2'd3, MODE_BACK, 7'd1);
    repeat (4) send_item(ACTION_TICK, 2'd3, MODE_BRAKE, 7'd127);
    send_item(ACTION_SET, 2'd2, MODE_NEUTRAL, 7'd64);
    send_item(ACTION_SET, 2'd0, MODE_NEUTRAL, 7'd0);
    send_item(ACTION_SET, 2'd1, MODE_FORWARD, 7'd101);
    send_item(ACTION_SET, 2'd3, MODE_BRAKE, 7'd127);
    send_item(ACTION_SET, 2'd0, MODE_BACK, 7'd99);
    send_item(ACTION_SET, 2'd2, MODE_FORWARD, 7'd50);
    repeat (4) send_item(ACTION_TICK, 2'd1, MODE_BACK, 7'd85);

    run_phase(100);
    change_period(16'd65535);
    run_phase(200);
    // leave the counter well above the next, shorter period
    repeat (100) send_random(ACTION_TICK);
    change_period(16'd71);
    run_phase(200);
    // period below the duty offset
    change_period(16'd50);
    run_phase(100);
    calm = 1'b1;
    change_period(16'd100);
    run_phase(200);
    calm = 1'b0;
    change_period(COUNT_W'($urandom_range(160, 72)));
    run_phase(200);
    change_period(COUNT_W'($urandom_range(160, 72)));
    run_phase(200);

    in_if.valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
